// ----- design/mlfq_pkg.sv -----
// Shared codes and constants for the three-level feedback queue scheduler.
package mlfq_pkg;

	localparam int unsigned NUM_LEVELS = 3;
	localparam logic [1:0] LVL_TOP = 2'd0;
	localparam logic [1:0] LVL_BOTTOM = 2'd2;

	localparam logic [1:0] OP_ADMIT = 2'd0;
	localparam logic [1:0] OP_REPORT = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_DISPATCHED = 3'd1;
	localparam logic [2:0] EV_COMPLETED = 3'd2;
	localparam logic [2:0] EV_REQUEUED = 3'd3;
	localparam logic [2:0] EV_IO = 3'd4;
	localparam logic [2:0] EV_REJECTED = 3'd5;

	localparam logic [1:0] REG_QUANTUM = 2'd0;
	localparam logic [1:0] REG_ALLOT = 2'd1;
	localparam logic [1:0] REG_BOOST = 2'd2;
	localparam logic [1:0] REG_CPUS = 2'd3;

	localparam logic [9:0] QUANTUM_RST = 10'd50;
	localparam logic [15:0] ALLOT_RST = 16'd200;
	localparam logic [23:0] BOOST_RST = 24'd1000;
	localparam logic [3:0] CPUS_RST = 4'd4;

	typedef struct packed {
		logic [19:0] remaining;
		logic [15:0] allot;
	} task_entry_t;

endpackage

// ----- design/mlfq_ram.sv -----
// Single-port-write, registered-read RAM for the task table and queue links.
module mlfq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/mlfq_task_scheduler.sv -----
// Top level of the three-level feedback queue task scheduler.
//
//  channel  | direction | handshake           | content
//  ---------+-----------+---------------------+-----------------------------------------
//  s_axis   | in        | tvalid/tready       | tuser: op; tdata: task, length, cpu, io
//  m_axis   | out       | tvalid/tready       | tuser: event; tdata: task, cpu, level, boost
//  cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Admit and rejected words are answered straight from idle, quantum reports read the task
// table then write it back, and ticks may boost and dispatch: a boost splices levels 1 and 2
// in a state each, and a dispatch reads the head's link before popping it.
// One word is in flight at a time; the next is taken once the result register is
// free or draining. Reset empties all levels, frees all CPUs and loads register defaults.
module mlfq_task_scheduler #(
	parameter int MAX_TASKS = 64,
	parameter int MAX_CPUS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [1:0]  s_axis_tuser,  // op
	input  logic [39:0] s_axis_tdata,  // task_id, exec_len, cpu_index, did_io, io_time
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [2:0]  m_axis_tuser,  // event_res
	output logic [15:0] m_axis_tdata,  // out_task, out_cpu, out_level, boosted, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int TIW = $clog2(MAX_TASKS);
	localparam int CIW = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int EW = $bits(mlfq_pkg::task_entry_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RPT = 3'd1;
	localparam logic [2:0] S_B1 = 3'd2;
	localparam logic [2:0] S_B2 = 3'd3;
	localparam logic [2:0] S_DISP = 3'd4;
	localparam logic [2:0] S_POP = 3'd5;

	logic [2:0] state_q;

	logic [9:0] quant_q;
	logic [15:0] allot_lim_q;
	logic [23:0] period_q;
	logic [3:0] cpus_q;
	logic [23:0] timer_q;

	logic [TIW-1:0] head_q [3];
	logic [TIW-1:0] tail_q [3];
	logic [CW-1:0] cnt_q [3];
	logic [MAX_TASKS-1:0] live_q;
	logic [MAX_CPUS-1:0] busy_q;
	logic [TIW-1:0] ctask_q [MAX_CPUS];
	logic [1:0] clvl_q [MAX_CPUS];

	logic [TIW-1:0] task_q;
	logic [CIW-1:0] cpu_q;
	logic [2:0] cpu_raw_q;
	logic dio_q;
	logic [9:0] iot_q;
	logic bst_q;
	logic [1:0] plv_q;

	logic ov_q;
	logic [2:0] oev_q;
	logic [5:0] otask_q;
	logic [2:0] ocpu_q;
	logic [1:0] olvl_q;
	logic obst_q;

	// input fields
	logic [1:0] in_op;
	logic [5:0] in_tid;
	logic [19:0] in_len;
	logic [2:0] in_ci;
	logic in_dio;
	logic [9:0] in_iot;
	assign in_op = s_axis_tuser;
	assign in_tid = s_axis_tdata[5:0];
	assign in_len = s_axis_tdata[25:6];
	assign in_ci = s_axis_tdata[28:26];
	assign in_dio = s_axis_tdata[29];
	assign in_iot = s_axis_tdata[39:30];

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE) && (!ov_q || m_axis_tready);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser = oev_q;
	assign m_axis_tdata = {4'd0, obst_q, olvl_q, ocpu_q, otask_q};

	// memories
	logic t_we;
	logic [TIW-1:0] t_waddr, t_raddr;
	mlfq_pkg::task_entry_t t_wdata, t_rdata;
	logic l_we;
	logic [TIW-1:0] l_waddr, l_raddr, l_wdata, l_rdata;

	mlfq_ram #(.DEPTH(MAX_TASKS), .WIDTH(EW)) u_task_ram (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	mlfq_ram #(.DEPTH(MAX_TASKS), .WIDTH(TIW)) u_link_ram (
		.clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
		.raddr(l_raddr), .rdata(l_rdata)
	);

	// decode of the accepted word
	logic tid_ok, ci_ok;
	logic [TIW-1:0] tid_idx;
	logic [CIW-1:0] ci_idx;
	assign tid_idx = TIW'(in_tid);
	assign ci_idx = CIW'(in_ci);
	assign tid_ok = (int'(in_tid) < MAX_TASKS) && !live_q[tid_idx];
	assign ci_ok = (int'(in_ci) < MAX_CPUS) && busy_q[ci_idx];

	// report evaluation
	logic [19:0] q20;
	logic [16:0] io_sum, q_sum;
	logic [15:0] io_allot, q_allot;
	logic fin, demote;
	logic [1:0] cur_lv, new_lv;
	assign q20 = 20'(quant_q);
	assign io_sum = {1'b0, t_rdata.allot} + 17'(iot_q);
	assign q_sum = {1'b0, t_rdata.allot} + 17'(quant_q);
	assign io_allot = io_sum[16] ? 16'hFFFF : io_sum[15:0];
	assign q_allot = q_sum[16] ? 16'hFFFF : q_sum[15:0];
	assign fin = t_rdata.remaining <= q20;
	assign demote = q_allot >= allot_lim_q;
	assign cur_lv = clvl_q[cpu_q];
	assign new_lv = (demote && cur_lv != mlfq_pkg::LVL_BOTTOM) ? cur_lv + 2'd1 : cur_lv;

	// dispatch search
	logic c_found, lv_found;
	logic [CIW-1:0] c_sel;
	logic [1:0] lv_sel;
	always_comb begin
		c_found = 1'b0;
		c_sel = '0;
		for (int c = 0; c < MAX_CPUS; c++) begin
			if (!c_found && !busy_q[c] && c < int'(cpus_q)) begin
				c_found = 1'b1;
				c_sel = CIW'(c);
			end
		end
		lv_found = 1'b0;
		lv_sel = mlfq_pkg::LVL_TOP;
		for (int l = 0; l < 3; l++) begin
			if (!lv_found && cnt_q[l] != '0) begin
				lv_found = 1'b1;
				lv_sel = 2'(l);
			end
		end
	end

	// queue append: admit into level 0, requeue into new level
	logic push_en;
	logic [1:0] push_lv;
	logic [TIW-1:0] push_t;
	logic admit_ok, rpt_requeue;
	logic [1:0] blv;
	assign admit_ok = accept && in_op == mlfq_pkg::OP_ADMIT && tid_ok;
	assign rpt_requeue = state_q == S_RPT && !dio_q && !fin;
	assign push_en = admit_ok || rpt_requeue;
	assign push_lv = admit_ok ? mlfq_pkg::LVL_TOP : new_lv;
	assign push_t = admit_ok ? tid_idx : task_q;
	assign blv = (state_q == S_B1) ? 2'd1 : 2'd2;

	always_comb begin
		t_we = 1'b0;
		t_waddr = task_q;
		t_wdata = t_rdata;
		t_raddr = ctask_q[ci_idx];
		l_we = 1'b0;
		l_waddr = tail_q[push_lv];
		l_wdata = push_t;
		l_raddr = head_q[lv_sel];
		if (admit_ok) begin
			t_we = 1'b1;
			t_waddr = tid_idx;
			t_wdata.remaining = in_len;
			t_wdata.allot = '0;
		end else if (state_q == S_RPT) begin
			t_we = 1'b1;
			if (dio_q) begin
				t_wdata.allot = io_allot;
			end else if (fin) begin
				t_wdata.remaining = '0;
			end else begin
				t_wdata.remaining = t_rdata.remaining - q20;
				t_wdata.allot = demote ? 16'd0 : q_allot;
			end
		end
		if (push_en) begin
			l_we = cnt_q[push_lv] != '0;
		end else if (state_q == S_B1 || state_q == S_B2) begin
			l_we = cnt_q[blv] != '0 && cnt_q[0] != '0;
			l_waddr = tail_q[0];
			l_wdata = head_q[blv];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			quant_q <= mlfq_pkg::QUANTUM_RST;
			allot_lim_q <= mlfq_pkg::ALLOT_RST;
			period_q <= mlfq_pkg::BOOST_RST;
			cpus_q <= mlfq_pkg::CPUS_RST;
			timer_q <= '0;
			for (int l = 0; l < 3; l++) begin
				head_q[l] <= '0;
				tail_q[l] <= '0;
				cnt_q[l] <= '0;
			end
			live_q <= '0;
			busy_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					mlfq_pkg::REG_QUANTUM: quant_q <= cfg_data[9:0];
					mlfq_pkg::REG_ALLOT: allot_lim_q <= cfg_data[15:0];
					mlfq_pkg::REG_BOOST: period_q <= cfg_data;
					mlfq_pkg::REG_CPUS: cpus_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			if (push_en) begin
				if (cnt_q[push_lv] == '0) begin
					head_q[push_lv] <= push_t;
				end
				tail_q[push_lv] <= push_t;
				cnt_q[push_lv] <= cnt_q[push_lv] + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cpu_raw_q <= in_ci;
						cpu_q <= ci_idx;
						task_q <= ctask_q[ci_idx];
						dio_q <= in_dio;
						iot_q <= in_iot;
						bst_q <= 1'b0;
						ov_q <= 1'b1;
						oev_q <= mlfq_pkg::EV_NONE;
						otask_q <= '0;
						ocpu_q <= '0;
						olvl_q <= '0;
						obst_q <= 1'b0;
						case (in_op)
							mlfq_pkg::OP_ADMIT: begin
								otask_q <= in_tid;
								if (tid_ok) begin
									live_q[tid_idx] <= 1'b1;
								end else begin
									oev_q <= mlfq_pkg::EV_REJECTED;
								end
							end
							mlfq_pkg::OP_REPORT: begin
								ocpu_q <= in_ci;
								if (ci_ok) begin
									ov_q <= 1'b0;
									state_q <= S_RPT;
								end else begin
									oev_q <= mlfq_pkg::EV_REJECTED;
								end
							end
							mlfq_pkg::OP_TICK: begin
								ov_q <= 1'b0;
								if (timer_q + 24'd1 >= period_q) begin
									timer_q <= '0;
									bst_q <= 1'b1;
									state_q <= S_B1;
								end else begin
									timer_q <= timer_q + 24'd1;
									state_q <= S_DISP;
								end
							end
							default: oev_q <= mlfq_pkg::EV_REJECTED;
						endcase
					end
				end
				S_RPT: begin
					ov_q <= 1'b1;
					otask_q <= 6'(task_q);
					ocpu_q <= cpu_raw_q;
					olvl_q <= cur_lv;
					if (dio_q) begin
						oev_q <= mlfq_pkg::EV_IO;
					end else if (fin) begin
						oev_q <= mlfq_pkg::EV_COMPLETED;
						busy_q[cpu_q] <= 1'b0;
						live_q[task_q] <= 1'b0;
					end else begin
						oev_q <= mlfq_pkg::EV_REQUEUED;
						busy_q[cpu_q] <= 1'b0;
						olvl_q <= new_lv;
					end
					state_q <= S_IDLE;
				end
				S_B1, S_B2: begin
					// splice the whole level onto the tail of level 0
					if (cnt_q[blv] != '0) begin
						if (cnt_q[0] == '0) begin
							head_q[0] <= head_q[blv];
						end
						tail_q[0] <= tail_q[blv];
						cnt_q[0] <= cnt_q[0] + cnt_q[blv];
						cnt_q[blv] <= '0;
					end
					state_q <= (state_q == S_B1) ? S_B2 : S_DISP;
				end
				S_DISP: begin
					if (c_found && lv_found) begin
						cpu_q <= c_sel;
						plv_q <= lv_sel;
						state_q <= S_POP;
					end else begin
						ov_q <= 1'b1;
						oev_q <= mlfq_pkg::EV_NONE;
						otask_q <= '0;
						ocpu_q <= '0;
						olvl_q <= '0;
						obst_q <= bst_q;
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					head_q[plv_q] <= l_rdata;
					cnt_q[plv_q] <= cnt_q[plv_q] - CW'(1);
					busy_q[cpu_q] <= 1'b1;
					ctask_q[cpu_q] <= head_q[plv_q];
					clvl_q[cpu_q] <= plv_q;
					ov_q <= 1'b1;
					oev_q <= mlfq_pkg::EV_DISPATCHED;
					otask_q <= 6'(head_q[plv_q]);
					ocpu_q <= 3'(cpu_q);
					olvl_q <= plv_q;
					obst_q <= bst_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/sv/mlfq_task_scheduler_test.sv -----
// Self-checking test of the feedback queue scheduler against a behavioral predictor.
`timescale 1ns / 1ps

module mlfq_task_scheduler_test;

	localparam int NTASK = 64;
	localparam int NCPU = 8;

	typedef struct {
		logic [1:0]  op;
		logic [5:0]  tid;
		logic [19:0] tlen;
		logic [2:0]  cpu;
		logic        dio;
		logic [9:0]  iot;
	} cmd_t;

	typedef struct packed {
		logic [2:0] ev;
		logic [5:0] tsk;
		logic [2:0] cpu;
		logic [1:0] lvl;
		logic       bst;
	} sched_ev_t;

	typedef struct {
		cmd_t      c;
		bit        typed;
		sched_ev_t e;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [1:0] s_axis_tuser = '0;
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [2:0] m_axis_tuser;
	logic [15:0] m_axis_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	always #1 clk = ~clk;

	mlfq_task_scheduler u_top (.*);

	// predictor state
	logic [9:0]  q_len;
	logic [15:0] allot_lim;
	logic [23:0] boost_per;
	logic [3:0]  n_cpus;
	logic [19:0] rem [NTASK];
	logic [15:0] used [NTASK];
	logic [1:0]  lvl_of [NTASK];
	logic [5:0]  link [NTASK];
	bit          live [NTASK];
	logic [5:0]  head [3];
	logic [5:0]  tail [3];
	int          cnt [3];
	bit          busy [NCPU];
	logic [5:0]  on_cpu [NCPU];
	logic [23:0] btimer;

	sched_ev_t pending_ev[$];
	int errors = 0;
	int n_results = 0, n_disp = 0, n_boost = 0, n_demote = 0;
	int send_idle = 0, recv_idle = 0;
	bit hold_recv = 0;

	function automatic logic [15:0] sat16(logic [15:0] a, logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	function automatic void enqueue(int lv, logic [5:0] t);
		if (cnt[lv] == 0) head[lv] = t;
		else link[tail[lv]] = t;
		tail[lv] = t;
		cnt[lv]++;
		lvl_of[t] = 2'(lv);
	endfunction

	function automatic void boost_all();
		logic [5:0] t;
		for (int lv = 1; lv < 3; lv++) begin
			if (cnt[lv] == 0) continue;
			t = head[lv];
			for (int i = 0; i < cnt[lv]; i++) begin
				lvl_of[t] = 0;
				t = link[t];
			end
			if (cnt[0] == 0) head[0] = head[lv];
			else link[tail[0]] = head[lv];
			tail[0] = tail[lv];
			cnt[0] += cnt[lv];
			cnt[lv] = 0;
		end
	endfunction

	function automatic sched_ev_t schedule(cmd_t c);
		sched_ev_t r;
		logic [5:0] t;
		int lv, ci, nc;
		r = '{mlfq_pkg::EV_NONE, 0, 0, 0, 0};
		case (c.op)
			mlfq_pkg::OP_ADMIT: begin
				r.tsk = c.tid;
				if (live[c.tid]) r.ev = mlfq_pkg::EV_REJECTED;
				else begin
					rem[c.tid] = c.tlen;
					used[c.tid] = 0;
					link[c.tid] = 0;
					live[c.tid] = 1;
					enqueue(0, c.tid);
				end
			end
			mlfq_pkg::OP_REPORT: begin
				r.cpu = c.cpu;
				if (!busy[c.cpu]) r.ev = mlfq_pkg::EV_REJECTED;
				else begin
					t = on_cpu[c.cpu];
					lv = int'(lvl_of[t]);
					r.tsk = t;
					if (c.dio) begin
						used[t] = sat16(used[t], 16'(c.iot));
						r.ev = mlfq_pkg::EV_IO;
					end else if (rem[t] <= 20'(q_len)) begin
						rem[t] = 0;
						busy[c.cpu] = 0;
						live[t] = 0;
						r.ev = mlfq_pkg::EV_COMPLETED;
					end else begin
						rem[t] -= 20'(q_len);
						used[t] = sat16(used[t], 16'(q_len));
						busy[c.cpu] = 0;
						if (used[t] >= allot_lim) begin
							if (lv < 2) lv++;
							used[t] = 0;
							n_demote++;
						end
						link[t] = 0;
						enqueue(lv, t);
						r.ev = mlfq_pkg::EV_REQUEUED;
					end
					r.lvl = 2'(lv);
				end
			end
			mlfq_pkg::OP_TICK: begin
				nc = int'(n_cpus) < NCPU ? int'(n_cpus) : NCPU;
				btimer = btimer + 24'd1;
				if (btimer >= boost_per) begin
					boost_all();
					btimer = 0;
					r.bst = 1;
					n_boost++;
				end
				for (ci = 0; ci < nc; ci++) if (!busy[ci]) break;
				if (ci < nc) begin
					for (lv = 0; lv < 3; lv++) if (cnt[lv] != 0) break;
					if (lv < 3) begin
						t = head[lv];
						head[lv] = link[t];
						cnt[lv]--;
						busy[ci] = 1;
						on_cpu[ci] = t;
						r = '{mlfq_pkg::EV_DISPATCHED, t, ci[2:0], lv[1:0], r.bst};
						n_disp++;
					end
				end
			end
			default: r.ev = mlfq_pkg::EV_REJECTED;
		endcase
		return r;
	endfunction

	task automatic send(cmd_t c, bit typed = 0, sched_ev_t want = '{0, 0, 0, 0, 0});
		sched_ev_t p;
		p = schedule(c);
		if (typed && p != want) begin
			$error("directed row: predictor %p differs from typed %p", p, want);
			errors++;
		end
		s_axis_tuser <= c.op;
		s_axis_tdata <= {c.iot, c.dio, c.cpu, c.tlen, c.tid};
		s_axis_tvalid <= 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_ev.push_back(typed ? want : p);
		@(negedge clk);
		if (send_idle > 0 && $urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			do @(negedge clk); while ($urandom_range(99) < send_idle);
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 0;
		case (idx)
			mlfq_pkg::REG_QUANTUM: q_len = val[9:0];
			mlfq_pkg::REG_ALLOT: allot_lim = val[15:0];
			mlfq_pkg::REG_BOOST: boost_per = val;
			default: n_cpus = val[3:0];
		endcase
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (pending_ev.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// receiver
	always @(negedge clk) begin
		if (hold_recv) m_axis_tready <= 0;
		else m_axis_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		sched_ev_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			n_results++;
			if (pending_ev.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				w = pending_ev.pop_front();
				if (m_axis_tuser !== w.ev) begin
					$error("event_res exp %0d got %0d", w.ev, m_axis_tuser); errors++;
				end
				if (m_axis_tdata[5:0] !== w.tsk) begin
					$error("out_task exp %0d got %0d", w.tsk, m_axis_tdata[5:0]); errors++;
				end
				if (m_axis_tdata[8:6] !== w.cpu) begin
					$error("out_cpu exp %0d got %0d", w.cpu, m_axis_tdata[8:6]); errors++;
				end
				if (m_axis_tdata[10:9] !== w.lvl) begin
					$error("out_level exp %0d got %0d", w.lvl, m_axis_tdata[10:9]);
					errors++;
				end
				if (m_axis_tdata[11] !== w.bst) begin
					$error("boosted exp %0d got %0d", w.bst, m_axis_tdata[11]); errors++;
				end
			end
		end
	end

	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

	function automatic cmd_t mk(logic [1:0] op, logic [5:0] tid = 0, logic [19:0] tlen = 0,
		logic [2:0] cpu = 0, logic dio = 0, logic [9:0] iot = 0);
		return '{op, tid, tlen, cpu, dio, iot};
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int k;
		c = mk(mlfq_pkg::OP_TICK);
		k = $urandom_range(99);
		c.tid = 6'($urandom);
		c.tlen = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(400));
		c.cpu = 3'($urandom);
		c.dio = ($urandom_range(3) == 0);
		c.iot = 10'($urandom);
		if (k < 30) c.op = mlfq_pkg::OP_ADMIT;
		else if (k < 62) begin
			c.op = mlfq_pkg::OP_REPORT;
			// mostly report from a busy CPU
			if ($urandom_range(9) != 0)
				for (int i = 0; i < 8; i++) if (busy[(c.cpu + i) % 8]) begin
					c.cpu = 3'((c.cpu + i) % 8);
					break;
				end
		end else if (k < 98) c.op = mlfq_pkg::OP_TICK;
		else c.op = 2'd3;
		return c;
	endfunction

	row_t dir_rows[$];

	initial begin
		q_len = mlfq_pkg::QUANTUM_RST; allot_lim = mlfq_pkg::ALLOT_RST;
		boost_per = mlfq_pkg::BOOST_RST; n_cpus = mlfq_pkg::CPUS_RST;
		btimer = 0;
		foreach (live[i]) begin
			live[i] = 0; rem[i] = 0; used[i] = 0; lvl_of[i] = 0; link[i] = 0;
		end
		foreach (busy[i]) begin
			busy[i] = 0; on_cpu[i] = 0;
		end
		foreach (cnt[i]) begin
			cnt[i] = 0; head[i] = 0; tail[i] = 0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed table
		dir_rows = '{
			'{mk(mlfq_pkg::OP_TICK), 1, '{mlfq_pkg::EV_NONE, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 7, 1, 10'h3FF), 1,
				'{mlfq_pkg::EV_REJECTED, 0, 7, 0, 0}},
			'{mk(2'd3, 63, 20'hFFFFF, 7, 1, 10'h3FF), 1,
				'{mlfq_pkg::EV_REJECTED, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_ADMIT, 63, 20'hFFFFF), 1, '{mlfq_pkg::EV_NONE, 63, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_ADMIT, 63, 5), 1, '{mlfq_pkg::EV_REJECTED, 63, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_ADMIT, 0, 0), 1, '{mlfq_pkg::EV_NONE, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_ADMIT, 1, 30), 1, '{mlfq_pkg::EV_NONE, 1, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_TICK), 1, '{mlfq_pkg::EV_DISPATCHED, 63, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_TICK), 1, '{mlfq_pkg::EV_DISPATCHED, 0, 1, 0, 0}},
			'{mk(mlfq_pkg::OP_TICK), 1, '{mlfq_pkg::EV_DISPATCHED, 1, 2, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 0, 1, 10'h3FF), 1,
				'{mlfq_pkg::EV_IO, 63, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 1), 1, '{mlfq_pkg::EV_COMPLETED, 0, 1, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 2), 1, '{mlfq_pkg::EV_COMPLETED, 1, 2, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 0), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_TICK), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 0, 1, 10'h155), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 0, 1, 10'h2AA), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_REPORT, 0, 0, 0), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_ADMIT, 6'h2A, 20'h55555), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_ADMIT, 6'h15, 20'hAAAAA), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_TICK), 0, '{0, 0, 0, 0, 0}},
			'{mk(mlfq_pkg::OP_TICK), 0, '{0, 0, 0, 0, 0}}
		};
		foreach (dir_rows[i]) send(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].e);
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(mlfq_pkg::REG_QUANTUM, 24'd1);
					write_reg(mlfq_pkg::REG_ALLOT, 24'd1);
					write_reg(mlfq_pkg::REG_BOOST, 24'd1);
					write_reg(mlfq_pkg::REG_CPUS, 24'd8);
				end
				1: begin
					write_reg(mlfq_pkg::REG_QUANTUM, 24'd1023);
					write_reg(mlfq_pkg::REG_ALLOT, 24'd65535);
					write_reg(mlfq_pkg::REG_BOOST, 24'hFFFFFF);
					write_reg(mlfq_pkg::REG_CPUS, 24'd1);
				end
				2: begin
					write_reg(mlfq_pkg::REG_QUANTUM, 24'd37);
					write_reg(mlfq_pkg::REG_ALLOT, 24'd90);
					write_reg(mlfq_pkg::REG_BOOST, 24'd15);
					write_reg(mlfq_pkg::REG_CPUS, 24'd3);
				end
				3: write_reg(mlfq_pkg::REG_CPUS, 24'd0);
				4: begin
					write_reg(mlfq_pkg::REG_CPUS, 24'd15);
					write_reg(mlfq_pkg::REG_BOOST, 24'd0);
				end
				default: begin
					write_reg(mlfq_pkg::REG_QUANTUM, 24'($urandom_range(1, 120)));
					write_reg(mlfq_pkg::REG_ALLOT, 24'($urandom_range(1, 400)));
					write_reg(mlfq_pkg::REG_BOOST, 24'($urandom_range(3, 60)));
					write_reg(mlfq_pkg::REG_CPUS, 24'($urandom_range(1, 8)));
				end
			endcase
			send_idle = ph < 2 ? 38 : (ph < 4 ? 66 : 0);
			recv_idle = ph < 2 ? 66 : (ph < 4 ? 38 : 0);
			if (ph == 5) fork
				begin
					hold_recv = 1;
					repeat (300) @(negedge clk);
					hold_recv = 0;
				end
			join_none
			repeat (150) send(rand_cmd());
			drain();
		end

		$display("covered %0d result words: %0d dispatches, %0d boosts, %0d demotions",
			n_results, n_disp, n_boost, n_demote);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
